/* hw/rtl/sha1bs_pkg.sv */
package sha1bs_pkg;

    localparam int unsigned NUM_CHAIN   = 5;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned ROUND_GROUP = 20;

    typedef logic [31:0] word_t;
    typedef logic [3:0]  word_addr_t;
    typedef logic [NUM_CHAIN-1:0][31:0] chain_t;

    localparam chain_t INIT_CHAIN = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam word_t K_GROUP0 = 32'h5A827999;
    localparam word_t K_GROUP1 = 32'h6ED9EBA1;
    localparam word_t K_GROUP2 = 32'h8F1BBCDC;
    localparam word_t K_GROUP3 = 32'hCA62C1D6;

    localparam logic [7:0]  PAD_MARKER      = 8'h80;
    localparam logic [5:0]  LEN_POS         = 6'd56;
    localparam logic [5:0]  LAST_FILL       = 6'd63;
    localparam logic [6:0]  FULL_BLOCK      = 7'd64;
    localparam logic [63:0] BITS_PER_BYTE   = 64'd8;
    localparam logic [2:0]  LAST_WORD_INDEX = 3'd4;

    typedef enum logic [1:0] {
        OP_ABSORB  = 2'd0,
        OP_FINISH  = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_AFTER_FINISH = 2'd1,
        STATUS_TOO_LONG     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPRESS,
        ST_EMIT
    } ctl_state_t;

    typedef enum logic [1:0] {
        CP_IDLE,
        CP_LOAD,
        CP_ROUND,
        CP_ADD
    } cmp_state_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
    } out_item_t;

    // How the loader fills a block: memory bytes below fill_limit, then an
    // optional 0x80 marker, then zeros, with the bit length in the tail if enabled.
    typedef struct packed {
        logic [6:0] fill_limit;
        logic       marker;
        logic       length;
    } pad_ctrl_t;

    typedef struct packed {
        logic [3:0] be;
        word_addr_t addr;
        word_t      data;
    } ram_wr_t;

    typedef struct packed {
        logic      start;
        logic      chain_init;
        pad_ctrl_t pad;
    } cmp_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cmp_rsp_t;

endpackage

/* hw/rtl/sha1bs_block_ram.sv */
module sha1bs_block_ram (
    input  logic                   aclk,
    input  sha1bs_pkg::ram_wr_t    wr,
    input  sha1bs_pkg::word_addr_t rd_addr,
    output sha1bs_pkg::word_t      rd_data
);
    import sha1bs_pkg::*;

    word_t mem [BLOCK_WORDS];
    word_t rd_data_reg;

    // Byte lanes: be[3] is the first byte of the word (bits 31:24).
    always_ff @(posedge aclk) begin
        for (int lane = 0; lane < 4; lane++) begin
            if (wr.be[lane]) begin
                mem[wr.addr][8*lane +: 8] <= wr.data[8*lane +: 8];
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/sha1bs_compress.sv */
module sha1bs_compress (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sha1bs_pkg::cmp_req_t   req,
    input  logic [63:0]            bit_count,
    output sha1bs_pkg::word_addr_t rd_addr,
    input  sha1bs_pkg::word_t      rd_data,
    output sha1bs_pkg::cmp_rsp_t   rsp,
    output sha1bs_pkg::chain_t     chain
);
    import sha1bs_pkg::*;

    cmp_state_t state_reg, state_next;
    logic [6:0] cnt_reg, cnt_next;
    pad_ctrl_t  pad_reg, pad_next;
    word_addr_t rd_word_reg;
    word_t      win_reg [BLOCK_WORDS];
    word_t      win_next [BLOCK_WORDS];
    word_t      a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t      a_next, b_next, c_next, d_next, e_next;
    chain_t     chain_reg, chain_next, chain_sum;
    word_t      load_word, sched_word, f_val, k_val, temp;

    function automatic logic [7:0] pad_byte(input logic [7:0] mem_byte,
                                            input logic [5:0] pos,
                                            input pad_ctrl_t pad,
                                            input logic [63:0] bits);
        logic [7:0] b;
        b = 8'h00;
        if ({1'b0, pos} < pad.fill_limit) begin
            b = mem_byte;
        end else if (pad.marker && {1'b0, pos} == pad.fill_limit) begin
            b = PAD_MARKER;
        end else if (pad.length && pos >= LEN_POS) begin
            b = bits[63 - 8*pos[2:0] -: 8];
        end
        return b;
    endfunction

    assign rd_addr = cnt_reg[3:0];

    // Build the padded word for the data now coming out of the memory.
    always_comb begin
        for (int lane = 0; lane < 4; lane++) begin
            load_word[31 - 8*lane -: 8] = pad_byte(rd_data[31 - 8*lane -: 8],
                                                   {rd_word_reg, 2'(lane)},
                                                   pad_reg, bit_count);
        end
    end

    always_comb begin
        sched_word = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        sched_word = {sched_word[30:0], sched_word[31]};
        if (cnt_reg < 7'(ROUND_GROUP)) begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K_GROUP0;
        end else if (cnt_reg < 7'(2*ROUND_GROUP)) begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_GROUP1;
        end else if (cnt_reg < 7'(3*ROUND_GROUP)) begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K_GROUP2;
        end else begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K_GROUP3;
        end
        temp = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + win_reg[0] + k_val;
        chain_sum[0] = chain_reg[0] + a_reg;
        chain_sum[1] = chain_reg[1] + b_reg;
        chain_sum[2] = chain_reg[2] + c_reg;
        chain_sum[3] = chain_reg[3] + d_reg;
        chain_sum[4] = chain_reg[4] + e_reg;
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pad_next   = pad_reg;
        chain_next = chain_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        for (int i = 0; i < BLOCK_WORDS; i++) begin
            win_next[i] = win_reg[i];
        end
        rsp.busy = (state_reg != CP_IDLE);
        rsp.done = 1'b0;

        case (state_reg)
            CP_IDLE: begin
            end
            CP_LOAD: begin
                // Data for the word addressed last cycle arrives now.
                if (cnt_reg != 7'd0) begin
                    for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                        win_next[i] = win_reg[i+1];
                    end
                    win_next[BLOCK_WORDS-1] = load_word;
                end
                if (cnt_reg == 7'(BLOCK_WORDS)) begin
                    cnt_next   = 7'd0;
                    state_next = CP_ROUND;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            CP_ROUND: begin
                for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[BLOCK_WORDS-1] = sched_word;
                a_next = temp;
                b_next = a_reg;
                c_next = {b_reg[1:0], b_reg[31:2]};
                d_next = c_reg;
                e_next = d_reg;
                if (cnt_reg == 7'(ROUNDS - 1)) begin
                    state_next = CP_ADD;
                end else begin
                    cnt_next = cnt_reg + 7'd1;
                end
            end
            CP_ADD: begin
                chain_next = chain_sum;
                rsp.done   = 1'b1;
                state_next = CP_IDLE;
            end
            default: begin
                state_next = CP_IDLE;
            end
        endcase

        // A new block may start right as the previous one folds in.
        if (req.start) begin
            pad_next   = req.pad;
            cnt_next   = 7'd0;
            state_next = CP_LOAD;
            if (state_reg == CP_ADD) begin
                a_next = chain_sum[0];
                b_next = chain_sum[1];
                c_next = chain_sum[2];
                d_next = chain_sum[3];
                e_next = chain_sum[4];
            end else begin
                a_next = chain_reg[0];
                b_next = chain_reg[1];
                c_next = chain_reg[2];
                d_next = chain_reg[3];
                e_next = chain_reg[4];
            end
        end
        if (req.chain_init) begin
            chain_next = INIT_CHAIN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CP_IDLE;
            cnt_reg   <= 7'd0;
            chain_reg <= INIT_CHAIN;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        pad_reg     <= pad_next;
        rd_word_reg <= rd_addr;
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
        for (int i = 0; i < BLOCK_WORDS; i++) begin
            win_reg[i] <= win_next[i];
        end
    end

    assign chain = chain_reg;

    a_start_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> (state_reg == CP_IDLE || state_reg == CP_ADD))
        else $error("compress start while a block is in flight");

    a_round_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == CP_ROUND |-> cnt_reg < 7'(ROUNDS))
        else $error("round counter past the last round");

endmodule

/* hw/rtl/sha1_byte_stream_hasher_unit.sv */
// Channel   Handshake          Payload                                     Dir
// s_        s_valid / s_ready  s_item: operation, data_byte                in
// m_        m_valid / m_ready  m_item: status, digest_word, word_index,    out
//                              last
//
// An absorb request that completes a 64-byte block holds s_ready low while
// the compressor streams the 16 block words out of the block memory, runs
// the 80 rounds and folds in the chaining values. A first finish runs one
// or two such compressions and then drives the five digest words, one per
// cycle while m_ready is high.
// Reset is synchronous on aresetn; the block memory needs no clearing pass,
// since every byte of a block is written or replaced by padding before use.
// A stall on m_ready holds the result register and closes s_ready.
module sha1_byte_stream_hasher_unit (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sha1bs_pkg::in_item_t  s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sha1bs_pkg::out_item_t m_item
);
    import sha1bs_pkg::*;

    ctl_state_t  state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bit_count_reg, bit_count_next;
    logic        finished_reg, finished_next;
    status_t     error_reg, error_next;
    logic        second_reg, second_next;
    logic        finishing_reg, finishing_next;
    logic [2:0]  idx_reg, idx_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_item_reg, m_item_next;

    logic        out_free;
    logic        out_load;
    out_item_t   out_data;
    logic [63:0] bit_sum;
    ram_wr_t     ram_wr;
    word_addr_t  rd_addr;
    word_t       rd_data;
    cmp_req_t    cmp_req;
    cmp_rsp_t    cmp_rsp;
    chain_t      chain;

    sha1bs_block_ram u_block_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sha1bs_compress u_compress (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req       (cmp_req),
        .bit_count (bit_count_reg),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .rsp       (cmp_rsp),
        .chain     (chain)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign bit_sum  = bit_count_reg + BITS_PER_BYTE;

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        bit_count_next = bit_count_reg;
        finished_next  = finished_reg;
        error_next     = error_reg;
        second_next    = second_reg;
        finishing_next = finishing_reg;
        idx_next       = idx_reg;
        s_ready        = 1'b0;
        out_load       = 1'b0;
        out_data       = '0;
        ram_wr         = '0;
        cmp_req        = '0;

        case (state_reg)
            ST_IDLE: begin
                // Accept only when the result register can take the answer.
                s_ready = out_free;
                if (s_valid && out_free) begin
                    case (op_t'(s_item.operation))
                        OP_ABSORB: begin
                            out_load      = 1'b1;
                            out_data.last = 1'b1;
                            if (finished_reg) begin
                                error_next      = STATUS_AFTER_FINISH;
                                out_data.status = STATUS_AFTER_FINISH;
                            end else if (error_reg != STATUS_OK) begin
                                out_data.status = error_reg;
                            end else begin
                                // Write the byte into its lane; lane 3 is the MSB byte.
                                ram_wr.be      = 4'b1000 >> fill_reg[1:0];
                                ram_wr.addr    = fill_reg[5:2];
                                ram_wr.data    = {4{s_item.data_byte}};
                                fill_next      = fill_reg + 6'd1;
                                bit_count_next = bit_sum;
                                if (bit_sum == 64'd0) begin
                                    error_next = STATUS_TOO_LONG;
                                end
                                if (fill_reg == LAST_FILL) begin
                                    cmp_req.start          = 1'b1;
                                    cmp_req.pad.fill_limit = FULL_BLOCK;
                                    finishing_next         = 1'b0;
                                    second_next            = 1'b0;
                                    state_next             = ST_COMPRESS;
                                end
                            end
                        end
                        OP_FINISH: begin
                            if (error_reg != STATUS_OK) begin
                                out_load        = 1'b1;
                                out_data.status = error_reg;
                                out_data.last   = 1'b1;
                            end else if (finished_reg) begin
                                idx_next   = 3'd0;
                                state_next = ST_EMIT;
                            end else begin
                                // Length fits after the marker only below byte 56.
                                cmp_req.start          = 1'b1;
                                cmp_req.pad.fill_limit = {1'b0, fill_reg};
                                cmp_req.pad.marker     = 1'b1;
                                cmp_req.pad.length     = (fill_reg < LEN_POS);
                                second_next            = (fill_reg >= LEN_POS);
                                finishing_next         = 1'b1;
                                state_next             = ST_COMPRESS;
                            end
                        end
                        OP_RESTART: begin
                            fill_next          = 6'd0;
                            bit_count_next     = 64'd0;
                            finished_next      = 1'b0;
                            error_next         = STATUS_OK;
                            cmp_req.chain_init = 1'b1;
                            out_load           = 1'b1;
                            out_data.last      = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_COMPRESS: begin
                if (cmp_rsp.done) begin
                    if (second_reg) begin
                        // Zero block carrying only the bit length.
                        cmp_req.start      = 1'b1;
                        cmp_req.pad.length = 1'b1;
                        second_next        = 1'b0;
                    end else if (finishing_reg) begin
                        finished_next  = 1'b1;
                        bit_count_next = 64'd0;
                        fill_next      = 6'd0;
                        idx_next       = 3'd0;
                        state_next     = ST_EMIT;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    out_data.status      = STATUS_OK;
                    out_data.digest_word = chain[idx_reg];
                    out_data.word_index  = idx_reg;
                    out_data.last        = (idx_reg == LAST_WORD_INDEX);
                    idx_next             = idx_reg + 3'd1;
                    if (idx_reg == LAST_WORD_INDEX) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Drop the held result once taken, load a new one when produced.
        m_valid_next = out_load ? 1'b1 : (m_valid_reg && !m_ready);
        m_item_next  = out_load ? out_data : m_item_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= 6'd0;
            bit_count_reg <= 64'd0;
            finished_reg  <= 1'b0;
            error_reg     <= STATUS_OK;
            second_reg    <= 1'b0;
            finishing_reg <= 1'b0;
            idx_reg       <= 3'd0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            bit_count_reg <= bit_count_next;
            finished_reg  <= finished_next;
            error_reg     <= error_next;
            second_reg    <= second_next;
            finishing_reg <= finishing_next;
            idx_reg       <= idx_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_rsp.busy |-> !s_ready)
        else $error("request accepted while a block is compressing");

    a_last_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.last && m_item.word_index != 3'd0)
            |-> m_item.word_index == LAST_WORD_INDEX)
        else $error("last flag on a digest word other than the final one");

    a_digest_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.word_index != 3'd0) |-> m_item.status == STATUS_OK)
        else $error("digest word carries an error status");

endmodule

/* dv/sha1bs_checker.sv */
`timescale 1ns / 100ps

module sha1bs_checker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  sha1bs_pkg::in_item_t  s_item,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  sha1bs_pkg::out_item_t m_item,
    output int                    fail_count,
    output int                    pending_count
);
    import sha1bs_pkg::*;

    // Shadow copy of the hasher state
    word_t      chain_h [NUM_CHAIN];
    logic [7:0] blk_buf [64];
    logic [6:0] fill_cnt;
    logic [63:0] msg_bits;
    logic       sealed;
    status_t    sticky_err;

    out_item_t  pending_results [$];
    int         mismatches = 0;

    assign fail_count = mismatches;

    function automatic word_t rotl(word_t x, int unsigned n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void clear_hash_state();
        int i;
        for (i = 0; i < NUM_CHAIN; i++) chain_h[i] = INIT_CHAIN[i];
        for (i = 0; i < 64; i++) blk_buf[i] = 8'h00;
        fill_cnt   = '0;
        msg_bits   = '0;
        sealed     = 1'b0;
        sticky_err = STATUS_OK;
    endfunction

    function automatic void compress_buf();
        word_t w [ROUNDS];
        word_t a, b, c, d, e, f, t, k;
        int    i;
        for (i = 0; i < BLOCK_WORDS; i++) begin
            w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
        end
        for (i = BLOCK_WORDS; i < ROUNDS; i++) begin
            w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        end
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (i = 0; i < ROUNDS; i++) begin
            case (i / ROUND_GROUP)
                0: begin
                    f = (b & c) | (~b & d);
                    k = K_GROUP0;
                end
                1: begin
                    f = b ^ c ^ d;
                    k = K_GROUP1;
                end
                2: begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K_GROUP2;
                end
                default: begin
                    f = b ^ c ^ d;
                    k = K_GROUP3;
                end
            endcase
            t = rotl(a, 5) + f + e + w[i] + k;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
        fill_cnt = '0;
    endfunction

    // Marker, zeros, then the 64-bit length; spills into a second block
    // when the marker lands in the length field.
    function automatic void seal_message();
        int pos;
        int i;
        pos = int'(fill_cnt[5:0]);
        blk_buf[pos] = PAD_MARKER;
        pos = pos + 1;
        if (pos > 56) begin
            while (pos < 64) begin
                blk_buf[pos] = 8'h00;
                pos = pos + 1;
            end
            compress_buf();
            pos = 0;
        end
        while (pos < 56) begin
            blk_buf[pos] = 8'h00;
            pos = pos + 1;
        end
        for (i = 0; i < 8; i++) blk_buf[56+i] = msg_bits[63-8*i -: 8];
        compress_buf();
        for (i = 0; i < 64; i++) blk_buf[i] = 8'h00;
        msg_bits = '0;
        sealed   = 1'b1;
    endfunction

    function automatic void queue_result(status_t st, word_t dw, logic [2:0] idx, logic lst);
        out_item_t r;
        r.status      = st;
        r.digest_word = dw;
        r.word_index  = idx;
        r.last        = lst;
        pending_results.push_back(r);
    endfunction

    function automatic void sha1_predict(in_item_t req);
        int k;
        case (req.operation)
            OP_ABSORB: begin
                if (sealed) begin
                    sticky_err = STATUS_AFTER_FINISH;
                    queue_result(STATUS_AFTER_FINISH, '0, '0, 1'b1);
                end else if (sticky_err != STATUS_OK) begin
                    queue_result(sticky_err, '0, '0, 1'b1);
                end else begin
                    blk_buf[fill_cnt[5:0]] = req.data_byte;
                    fill_cnt = {1'b0, fill_cnt[5:0]} + 7'd1;
                    msg_bits = msg_bits + BITS_PER_BYTE;
                    if (msg_bits == '0) sticky_err = STATUS_TOO_LONG;
                    if (fill_cnt == FULL_BLOCK) compress_buf();
                    queue_result(STATUS_OK, '0, '0, 1'b1);
                end
            end
            OP_FINISH: begin
                if (sticky_err != STATUS_OK) begin
                    queue_result(sticky_err, '0, '0, 1'b1);
                end else begin
                    if (!sealed) seal_message();
                    for (k = 0; k < NUM_CHAIN; k++) begin
                        queue_result(STATUS_OK, chain_h[k], 3'(k), 3'(k) == LAST_WORD_INDEX);
                    end
                end
            end
            OP_RESTART: begin
                clear_hash_state();
                queue_result(STATUS_OK, '0, '0, 1'b1);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            clear_hash_state();
            pending_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result mismatch, expected none, got status %0d word 0x%0h",
                             $time, m_item.status, m_item.digest_word);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status", 32'(want.status), 32'(m_item.status));
                    check_field("digest_word", want.digest_word, m_item.digest_word);
                    check_field("word_index", 32'(want.word_index), 32'(m_item.word_index));
                    check_field("last", 32'(want.last), 32'(m_item.last));
                end
            end
            if (s_valid && s_ready) sha1_predict(s_item);
        end
        pending_count <= pending_results.size();
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import sha1bs_pkg::*;

    // No-progress limit: covers a two-block finish plus the longest gap and
    // stall bursts, with a wide margin.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 250;
    localparam int TARGET_REQS    = 280;
    localparam int QUIET_FROM     = 240;

    logic      aclk;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b1;
    out_item_t m_item;

    int fail_count;
    int pending_count;

    // Idle odds in percent, re-rolled per message; zero gives calm stretches
    int  gap_pct   = 0;
    int  stall_pct = 0;
    bit  quiet     = 1'b0;

    int  n_reqs     = 0;
    int  n_finish   = 0;
    int  n_restart  = 0;
    int  longest    = 0;

    sha1_byte_stream_hasher_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    sha1bs_checker u_chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Present one request and hold it until the hasher takes it. Returns in
    // the time step of the accepting edge, so the next request can follow
    // back to back with valid left high.
    task automatic send_req(input op_t op, input logic [7:0] byte_val);
        in_item_t req;
        req.operation = op;
        req.data_byte = byte_val;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            // drop valid for a burst of idle cycles
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= req;
        do @(posedge aclk); while (!s_ready);
        n_reqs++;
        if (op == OP_FINISH) n_finish++;
        if (op == OP_RESTART) n_restart++;
    endtask

    // Absorb a run of random bytes
    task automatic absorb_bytes(input int count);
        int i;
        for (i = 0; i < count; i++) send_req(OP_ABSORB, 8'($urandom_range(0, 255)));
        if (count > longest) longest = count;
    endtask

    // Result side back-pressure: stall m_ready in random bursts, never in
    // the quiet tail of the run.
    initial begin
        forever begin
            @(posedge aclk);
            if (!quiet && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge aclk);
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int unsigned pad_lens [4];
        int          kind;
        int          len;
        int          half;
        int          p;
        int          odds [3];

        // Byte counts that put the pad marker right before the length
        // field, at its first byte, at the last byte, and on a fresh block.
        pad_lens = '{55, 56, 63, 64};
        odds     = '{0, 15, 40};

        // hold reset, then release it once
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty message, repeated finish, error paths, short text,
        // extreme byte values and a restart in the middle of a message.
        send_req(OP_RESTART, 8'hFF);
        send_req(OP_FINISH,  8'h00);
        send_req(OP_FINISH,  8'hFF);
        send_req(OP_ABSORB,  8'h00);   // absorb after finish sets the sticky error
        send_req(OP_ABSORB,  8'hFF);   // still in error
        send_req(OP_FINISH,  8'h5A);   // finish reports the error
        send_req(OP_RESTART, 8'h00);
        send_req(OP_ABSORB,  8'h61);
        send_req(OP_ABSORB,  8'h62);
        send_req(OP_ABSORB,  8'h63);
        send_req(OP_FINISH,  8'hA5);
        send_req(OP_RESTART, 8'h3C);
        send_req(OP_ABSORB,  8'hFF);
        send_req(OP_ABSORB,  8'h00);
        send_req(OP_ABSORB,  8'hAA);
        send_req(OP_ABSORB,  8'h55);
        send_req(OP_FINISH,  8'hC3);
        send_req(OP_RESTART, 8'hFF);
        send_req(OP_ABSORB,  8'h80);
        send_req(OP_RESTART, 8'h01);   // abandon a message halfway
        send_req(OP_FINISH,  8'h80);

        // Random: mostly well-formed messages (restart, bytes, finish) with
        // random content; a few skip the restart, restart midway or absorb
        // after the finish.
        while (n_reqs < TARGET_REQS) begin
            if (n_reqs >= QUIET_FROM) quiet = 1'b1;
            gap_pct   = odds[$urandom_range(0, 2)];
            stall_pct = odds[$urandom_range(0, 2)];
            kind      = $urandom_range(0, 9);
            if ($urandom_range(0, 9) < 3) len = pad_lens[$urandom_range(0, 3)];
            else len = $urandom_range(0, 12);

            if (kind != 0) send_req(OP_RESTART, 8'($urandom_range(0, 255)));
            if (kind == 1) begin
                half = len / 2;
                absorb_bytes(half);
                send_req(OP_RESTART, 8'($urandom_range(0, 255)));
                absorb_bytes(len - half);
            end else begin
                absorb_bytes(len);
            end
            send_req(OP_FINISH, 8'($urandom_range(0, 255)));
            p = $urandom_range(0, 3);
            if (p == 0) send_req(OP_FINISH, 8'($urandom_range(0, 255)));
            if (kind == 2) begin
                send_req(OP_ABSORB, 8'($urandom_range(0, 255)));
                send_req(OP_FINISH, 8'($urandom_range(0, 255)));
            end
        end

        // release the request channel and let the digests drain
        s_valid <= 1'b0;
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (pending_count != 0) begin
            $display("%0t: result mismatch, expected %0d more results, got none",
                     $time, pending_count);
        end
        $display("Sent %0d requests: %0d finishes, %0d restarts, longest message %0d bytes,",
                 n_reqs, n_finish, n_restart, longest);
        $display("with one- and two-block padding, sticky errors and random idle bursts.");
        if (fail_count == 0 && pending_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
